[rtl/hll_pkg.sv]
// Shared constants, types and command/status structs for the HyperLogLog sketch.
`timescale 1ns / 1ps
package hll_pkg;

   localparam int INDEX_BITS = 14;
   localparam int REG_COUNT  = 1 << INDEX_BITS;
   localparam int SUM_FRAC   = 63 - INDEX_BITS;
   localparam int HASH_W     = 64;
   localparam int REST_W     = HASH_W - INDEX_BITS;
   localparam int RANK_W     = 6;
   localparam int ZERO_W     = INDEX_BITS + 1;
   localparam int SUM_W      = 64;
   localparam int EST_W      = 48;
   localparam int K_W        = 5;
   localparam int LOG_W      = 32 + K_W;
   localparam int DIV_STEPS  = 128;

   localparam logic [RANK_W-1:0] RANK_CAP = RANK_W'(65 - INDEX_BITS);

   // alpha in Q16, rounded to nearest
   localparam longint unsigned ALPHA_NUM = 64'd7213 * 64'(REG_COUNT) * 64'd65536;
   localparam longint unsigned ALPHA_DEN = 64'd10 * (64'd1000 * 64'(REG_COUNT) + 64'd1079);
   localparam longint unsigned ALPHA_Q16 =
      (INDEX_BITS == 4) ? 64'd44106 :
      (INDEX_BITS == 5) ? 64'd45679 :
      (INDEX_BITS == 6) ? 64'd46465 :
      (64'd2 * ALPHA_NUM + ALPHA_DEN) / (64'd2 * ALPHA_DEN);

   localparam logic [DIV_STEPS-1:0] DIVIDEND = DIV_STEPS'(ALPHA_Q16) << (INDEX_BITS + 55);

   // small-range threshold: 2.5*m in Q8
   localparam logic [EST_W-1:0] THRESH = EST_W'(640 * REG_COUNT);
   localparam logic [31:0]      LN2_Q32 = 32'd2977044472;

   typedef enum logic [1:0] {
      OP_INSERT   = 2'd0,
      OP_ESTIMATE = 2'd1,
      OP_CLEAR    = 2'd2,
      OP_NOP      = 2'd3
   } opcode_type;

   typedef struct packed {
      logic                  load;      // capture request beat
      logic                  mem_re;
      logic                  mem_we;
      logic                  wzero;     // write zero (clear) instead of rank
      logic                  use_cnt;   // address from sweep counter
      logic [INDEX_BITS-1:0] cnt;
      logic                  acc_clr;
      logic                  scan_rd;
      logic                  div_start;
      logic                  log_start;
      logic                  mul_en;
      logic                  out_load;
   } cmd_type;

   typedef struct packed {
      logic div_done;
      logic log_done;
      logic use_lin;
   } sts_type;

endpackage

[rtl/hyperloglog_cardinality_sketch_top.sv]
// Top level of the HyperLogLog cardinality sketch.
`timescale 1ns / 1ps
// HyperLogLog sketch with 2^14 six-bit rank registers held in one single-port
// memory. Each request beat carries an opcode in req_tuser (insert, estimate,
// clear, no-op) and a 64-bit precomputed hash in req_tdata. An insert is a
// read-modify-write of one memory entry, a read state then a write state;
// the next request can be taken during the write. An estimate walks every
// register through the memory read port, then runs a 128-step bit-serial
// divider and, for small counts, a 32-step log unit; the result beat then
// waits while the result side stalls. A clear sweeps the memory one entry
// per cycle. After reset the same sweep runs, with req_tready low. Only an
// estimate returns a result beat: unsigned Q8, saturating at 2^48-1.
module hyperloglog_cardinality_sketch_top (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [63:0]  req_tdata,   // [63:0] hash_value
   input  logic [1:0]   req_tuser,   // [1:0] opcode
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [47:0]  rsp_tdata    // [47:0] cardinality_estimate
);
   import hll_pkg::*;

   cmd_type cmd;
   sts_type sts;

   hll_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .opcode     (req_tuser),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   hll_dp u_dp (
      .clock   (clock),
      .reset   (reset),
      .cmd     (cmd),
      .hash_in (req_tdata),
      .sts     (sts),
      .est_out (rsp_tdata)
   );

endmodule

[rtl/hll_div.sv]
// Restoring divider: constant dividend over the register sum, one bit per cycle.
`timescale 1ns / 1ps
module hll_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [hll_pkg::SUM_W-1:0]    divisor,
   output logic [hll_pkg::EST_W-1:0]    quot,
   output logic                         done
);
   import hll_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [6:0]           cnt_ff, cnt_in;
   logic [SUM_W-1:0]     rem_ff, rem_in;
   logic [EST_W-1:0]     q_ff, q_in;
   logic                 sat_ff, sat_in;
   logic [SUM_W:0]       shifted;
   logic                 ge;

   // one quotient bit per step
   always_comb begin
      shifted = {rem_ff, DIVIDEND[cnt_ff]};
      ge      = shifted >= {1'b0, divisor};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      q_in    = q_ff;
      sat_in  = sat_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = 7'(DIV_STEPS - 1);
         rem_in  = '0;
         q_in    = '0;
         sat_in  = 1'b0;
      end else if (busy_ff) begin
         rem_in = ge ? SUM_W'(shifted - {1'b0, divisor}) : shifted[SUM_W-1:0];
         sat_in = sat_ff | q_ff[EST_W-1];
         q_in   = {q_ff[EST_W-2:0], ge};
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      q_ff   <= q_in;
      sat_ff <= sat_in;
   end

   assign quot = sat_ff ? {EST_W{1'b1}} : q_ff;
   assign done = done_ff;

endmodule

[rtl/hll_log.sv]
// Base-2 logarithm in Q32 by repeated squaring, one fraction bit per cycle.
`timescale 1ns / 1ps
module hll_log (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [hll_pkg::ZERO_W-1:0]   z,
   output logic [hll_pkg::LOG_W-1:0]    log2_q32,
   output logic                         done
);
   import hll_pkg::*;

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [5:0]       cnt_ff, cnt_in;
   logic [K_W-1:0]   k_ff, k_in;
   logic [31:0]      x_ff, x_in;
   logic [31:0]      frac_ff, frac_in;
   logic [K_W-1:0]   msb;
   logic [63:0]      sq;
   logic [32:0]      y;

   // leading one of the zero count
   always_comb begin
      msb = '0;
      for (int i = 0; i < ZERO_W; i++) begin
         if (z[i]) msb = K_W'(i);
      end
   end

   assign sq = 64'(x_ff) * 64'(x_ff);
   assign y  = sq[63:31];

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      k_in    = k_ff;
      x_in    = x_ff;
      frac_in = frac_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = 6'd31;
         k_in    = msb;
         x_in    = 32'(z) << (5'd31 - msb);
         frac_in = '0;
      end else if (busy_ff) begin
         x_in    = y[32] ? y[32:1] : y[31:0];
         frac_in = {frac_ff[30:0], y[32]};
         cnt_in  = cnt_ff - 6'd1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff  <= cnt_in;
      k_ff    <= k_in;
      x_ff    <= x_in;
      frac_ff <= frac_in;
   end

   assign log2_q32 = {k_ff, frac_ff};
   assign done     = done_ff;

endmodule

[rtl/hll_dp.sv]
// Datapath: rank memory, rank encoder, scan accumulators, divider, log and output.
`timescale 1ns / 1ps
module hll_dp (
   input  logic                         clock,
   input  logic                         reset,
   input  hll_pkg::cmd_type             cmd,
   input  logic [hll_pkg::HASH_W-1:0]   hash_in,
   output hll_pkg::sts_type             sts,
   output logic [hll_pkg::EST_W-1:0]    est_out
);
   import hll_pkg::*;

   logic [RANK_W-1:0]     rank_mem [REG_COUNT];
   logic [RANK_W-1:0]     rdata_ff;
   logic [HASH_W-1:0]     hash_ff;
   logic [RANK_W-1:0]     rank_ff, rank_in;
   logic                  scan_vld_ff;
   logic [SUM_W-1:0]      sum_ff, sum_in;
   logic [ZERO_W-1:0]     zeros_ff, zeros_in;
   logic [INDEX_BITS-1:0] addr;
   logic                  we;
   logic [RANK_W-1:0]     wdata;
   logic [REST_W-1:0]     rest, lowbit;
   logic [RANK_W-1:0]     tz;
   logic [SUM_W-1:0]      term;
   logic [EST_W-1:0]      raw;
   logic                  div_done, log_done;
   logic [LOG_W-1:0]      log_q;
   logic [LOG_W-1:0]      d;
   logic [63:0]           plo_ff;
   logic [63:0]           phi_ff;
   logic [63:0]           t;
   logic [64+INDEX_BITS-1:0] tl;
   logic [EST_W-1:0]      lin;
   logic [EST_W-1:0]      est_ff;

   // rank = 1 + trailing zeros of the bits above the index, capped
   assign rest   = hash_ff[HASH_W-1:INDEX_BITS];
   assign lowbit = rest & (~rest + REST_W'(1));
   always_comb begin
      tz = '0;
      for (int i = 0; i < REST_W; i++) begin
         if (lowbit[i]) tz = tz | RANK_W'(i);
      end
      rank_in = (rest == '0) ? RANK_CAP : tz + RANK_W'(1);
   end

   // memory port
   assign addr  = cmd.use_cnt ? cmd.cnt : hash_ff[INDEX_BITS-1:0];
   assign we    = cmd.mem_we & (cmd.wzero | (rank_ff > rdata_ff));
   assign wdata = cmd.wzero ? '0 : rank_ff;

   always_ff @(posedge clock) begin
      if (we) rank_mem[addr] <= wdata;
      if (cmd.mem_re) rdata_ff <= rank_mem[addr];
   end

   // scan accumulation of 2^-r and of the zero count
   assign term = (rdata_ff <= RANK_W'(SUM_FRAC)) ?
                 (SUM_W'(1) << (RANK_W'(SUM_FRAC) - rdata_ff)) : '0;
   always_comb begin
      sum_in   = sum_ff;
      zeros_in = zeros_ff;
      if (cmd.acc_clr) begin
         sum_in   = '0;
         zeros_in = '0;
      end else if (scan_vld_ff) begin
         sum_in   = sum_ff + term;
         zeros_in = zeros_ff + ZERO_W'(rdata_ff == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_vld_ff <= 1'b0;
      end else begin
         scan_vld_ff <= cmd.scan_rd;
      end
      if (cmd.load) hash_ff <= hash_in;
      rank_ff  <= rank_in;
      sum_ff   <= sum_in;
      zeros_ff <= zeros_in;
   end

   hll_div u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (cmd.div_start),
      .divisor (sum_ff),
      .quot    (raw),
      .done    (div_done)
   );

   hll_log u_log (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.log_start),
      .z        (zeros_ff),
      .log2_q32 (log_q),
      .done     (log_done)
   );

   // linear count: ln(m/zeros) * m
   assign d = {K_W'(INDEX_BITS), 32'd0} - log_q;
   always_ff @(posedge clock) begin
      if (cmd.mul_en) begin
         plo_ff <= 64'(d[31:0]) * 64'(LN2_Q32);
         phi_ff <= 64'(d[LOG_W-1:32]) * 64'(LN2_Q32);
      end
   end
   assign t   = phi_ff + {32'd0, plo_ff[63:32]};
   assign tl  = (64+INDEX_BITS)'(t) << INDEX_BITS;
   assign lin = (|tl[64+INDEX_BITS-1:EST_W+24]) ? {EST_W{1'b1}} : tl[EST_W+23:24];

   assign sts.div_done = div_done;
   assign sts.log_done = log_done;
   assign sts.use_lin  = (raw <= THRESH) && (zeros_ff != '0);

   // result register
   always_ff @(posedge clock) begin
      if (cmd.out_load) est_ff <= sts.use_lin ? lin : raw;
   end
   assign est_out = est_ff;

endmodule

[rtl/hll_ctrl.sv]
// Controller: sequences insert, scan/estimate and clearing sweeps.
`timescale 1ns / 1ps
module hll_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   input  logic [1:0]           opcode,
   output logic                 req_tready,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  hll_pkg::sts_type     sts,
   output hll_pkg::cmd_type     cmd
);
   import hll_pkg::*;

   typedef enum logic [3:0] {
      ST_CLR, ST_IDLE, ST_INS_RD, ST_INS_WR, ST_SCAN, ST_TAIL,
      ST_DIV_GO, ST_DIV_WAIT, ST_LOG_GO, ST_LOG_WAIT, ST_MUL, ST_OUT
   } state_type;

   state_type             state_ff, state_in;
   logic [INDEX_BITS-1:0] cnt_ff, cnt_in;
   logic                  vld_ff, vld_in;
   logic                  accept;
   logic                  slot_free;
   opcode_type            op;

   assign op         = opcode_type'(opcode);
   assign req_tready = (state_ff == ST_IDLE) || (state_ff == ST_INS_WR);
   assign accept     = req_tvalid && req_tready;
   assign slot_free  = !vld_ff || rsp_tready;
   assign rsp_tvalid = vld_ff;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      vld_in   = vld_ff && !rsp_tready;
      cmd      = '0;
      cmd.cnt  = cnt_ff;
      cmd.load = accept;
      unique case (state_ff)
         ST_CLR: begin
            cmd.mem_we  = 1'b1;
            cmd.wzero   = 1'b1;
            cmd.use_cnt = 1'b1;
            cnt_in      = cnt_ff + INDEX_BITS'(1);
            if (cnt_ff == '1) state_in = ST_IDLE;
         end
         ST_INS_RD: begin
            cmd.mem_re = 1'b1;
            state_in   = ST_INS_WR;
         end
         ST_SCAN: begin
            cmd.mem_re  = 1'b1;
            cmd.use_cnt = 1'b1;
            cmd.scan_rd = 1'b1;
            cnt_in      = cnt_ff + INDEX_BITS'(1);
            if (cnt_ff == '1) state_in = ST_TAIL;
         end
         ST_TAIL: state_in = ST_DIV_GO;
         ST_DIV_GO: begin
            cmd.div_start = 1'b1;
            state_in      = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (sts.div_done) state_in = sts.use_lin ? ST_LOG_GO : ST_OUT;
         end
         ST_LOG_GO: begin
            cmd.log_start = 1'b1;
            state_in      = ST_LOG_WAIT;
         end
         ST_LOG_WAIT: begin
            if (sts.log_done) state_in = ST_MUL;
         end
         ST_MUL: begin
            cmd.mul_en = 1'b1;
            state_in   = ST_OUT;
         end
         ST_OUT: begin
            if (slot_free) begin
               cmd.out_load = 1'b1;
               vld_in       = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_IDLE, ST_INS_WR: begin
            if (state_ff == ST_INS_WR) begin
               cmd.mem_we = 1'b1;
               state_in   = ST_IDLE;
            end
            if (accept) begin
               cnt_in = '0;
               unique case (op)
                  OP_INSERT:   state_in = ST_INS_RD;
                  OP_ESTIMATE: begin
                     cmd.acc_clr = 1'b1;
                     state_in    = ST_SCAN;
                  end
                  OP_CLEAR:    state_in = ST_CLR;
                  OP_NOP:      state_in = ST_IDLE;
                  default:     state_in = ST_IDLE;
               endcase
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLR;
         cnt_ff   <= '0;
         vld_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         vld_ff   <= vld_in;
      end
   end

endmodule

[rtl/hll_checker.sv]
// Port-level checker for the HyperLogLog sketch, bound to the top level.
`timescale 1ns / 1ps
module hll_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [1:0]  req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [47:0] rsp_tdata
);
   import hll_pkg::*;

   // result beat holds while stalled
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result beat dropped or changed while stalled");

   // clearing sweep follows reset
   assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !req_tready)
      else $error("request accepted during clearing sweep");

   // only an estimate produces a result
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser != OP_ESTIMATE) |=> !$rose(rsp_tvalid))
      else $error("result without an estimate request");

   // an estimate occupies the block while registers are scanned
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser == OP_ESTIMATE) |=> !req_tready)
      else $error("request accepted during estimate scan");

endmodule

bind hyperloglog_cardinality_sketch_top hll_checker u_hll_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
